// ===== rtl/core/alunz_pkg.sv =====
// ----------------------------------------------------------------------------
// alunz_pkg
// Shared types, opcodes and handshake structs for the ALU execute stage
// with N and Z condition codes.
// ----------------------------------------------------------------------------
package alunz_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int HALF_BITS = 16;
  localparam int OP_BITS   = 5;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // last step index of the bit-serial divider
  localparam cnt_t  DIV_LAST = cnt_t'(WORD_BITS - 1);
  // low half-word select used by LDH and LDL
  localparam word_t LOW_MASK = word_t'({HALF_BITS{1'b1}});

  typedef enum logic [OP_BITS-1:0] {
    OP_MOV  = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_MUL  = 5'd3,
    OP_DIV  = 5'd4,
    OP_CMP  = 5'd5,
    OP_AND  = 5'd6,
    OP_OR   = 5'd7,
    OP_XOR  = 5'd8,
    OP_SWAP = 5'd9,
    OP_SHL  = 5'd10,
    OP_SHR  = 5'd11,
    OP_SAR  = 5'd12,
    OP_LDH  = 5'd13,
    OP_LDL  = 5'd14,
    OP_NOT  = 5'd15,
    OP_JMP  = 5'd16,
    OP_JZ   = 5'd17,
    OP_JP   = 5'd18,
    OP_JN   = 5'd19,
    OP_JNZ  = 5'd20,
    OP_JNP  = 5'd21,
    OP_JNN  = 5'd22
  } op_t;

  typedef struct packed {
    logic [OP_BITS-1:0]          req_type;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result;
    logic signed [WORD_BITS-1:0] second_value;
    logic                        write_result;
    logic                        write_second;
    logic                        flag_negative;
    logic                        flag_zero;
    logic                        branch_taken;
    logic                        divide_error;
  } rsp_t;

  // how long the datapath works on a request
  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_MUL,
    KIND_DIV
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_cap;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_last;
  } sts_t;

endpackage

// ===== rtl/core/alu_execute_with_nz_flags.sv =====
// ----------------------------------------------------------------------------
// alu_execute_with_nz_flags
// A single-step op goes from the accept edge through S_FIN to rsp_valid; MUL
// passes S_MUL first (registered multiplier), and DIV with a nonzero divisor
// passes S_DIV first (one quotient bit per cycle in the restoring divider).
// req_stall stays high until the controller is back in S_IDLE, as it handles
// one request at a time; a waiting response holds it in S_FIN.
// Reset clears the N and Z flags, the controller state and rsp_valid.
// ----------------------------------------------------------------------------
module alu_execute_with_nz_flags (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  alunz_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output alunz_pkg::rsp_t rsp
);

  alunz_pkg::cmd_t cmd;
  alunz_pkg::sts_t sts;

  // sequencing
  alunz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, flags and response register
  alunz_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ===== rtl/core/alunz_dp.sv =====
// ----------------------------------------------------------------------------
// alunz_dp
// Datapath: operand registers, registered multiplier, bit-serial restoring
// divider, result logic, N/Z flags and the response register.
// ----------------------------------------------------------------------------
module alunz_dp (
  input  logic            clk,
  input  logic            rst,
  input  alunz_pkg::req_t req,
  input  alunz_pkg::cmd_t cmd,
  output alunz_pkg::sts_t sts,
  output alunz_pkg::rsp_t rsp
);

  localparam int W = alunz_pkg::WORD_BITS;

  logic [alunz_pkg::OP_BITS-1:0] op_q;
  alunz_pkg::word_t              a_q;
  alunz_pkg::word_t              b_q;
  alunz_pkg::word_t              prod;
  alunz_pkg::word_t              rem;
  alunz_pkg::word_t              quo;
  alunz_pkg::word_t              dvs;
  logic                          neg_a;
  logic                          neg_b;
  alunz_pkg::cnt_t               cnt;
  logic                          flag_n;
  logic                          flag_z;
  alunz_pkg::rsp_t               rsp_q;

  alunz_pkg::word_t in_a;
  alunz_pkg::word_t in_b;
  alunz_pkg::word_t mag_a;
  alunz_pkg::word_t mag_b;
  alunz_pkg::word_t prod_next;
  alunz_pkg::word_t rem_next;
  alunz_pkg::word_t quo_next;
  logic [W:0]       trial;

  // classify the incoming request for the controller
  assign in_a  = alunz_pkg::word_t'(req.operand_a);
  assign in_b  = alunz_pkg::word_t'(req.operand_b);
  assign mag_a = in_a[W-1] ? (~in_a + 1'b1) : in_a;
  assign mag_b = in_b[W-1] ? (~in_b + 1'b1) : in_b;

  always_comb begin
    sts.kind = alunz_pkg::KIND_ONE;
    if (req.req_type == alunz_pkg::OP_MUL) begin
      sts.kind = alunz_pkg::KIND_MUL;
    end else if (req.req_type == alunz_pkg::OP_DIV && in_b != '0) begin
      sts.kind = alunz_pkg::KIND_DIV;
    end
    sts.div_last = (cnt == alunz_pkg::DIV_LAST);
  end

  // low word of the product
  assign prod_next = a_q * b_q;

  // one restoring divide step: shift in the next dividend bit, try subtract
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};
  always_comb begin
    if (!trial[W]) begin
      rem_next = trial[W-1:0];
      quo_next = {quo[W-2:0], 1'b1};
    end else begin
      rem_next = {rem[W-2:0], quo[W-1]};
      quo_next = {quo[W-2:0], 1'b0};
    end
  end

  // capture operands, run multiplier and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req.req_type;
      a_q   <= in_a;
      b_q   <= in_b;
      quo   <= mag_a;
      dvs   <= mag_b;
      rem   <= '0;
      cnt   <= '0;
      neg_a <= in_a[W-1];
      neg_b <= in_b[W-1];
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + 1'b1;
    end
    if (cmd.mul_cap) begin
      prod <= prod_next;
    end
  end

  // result logic on the held request
  alunz_pkg::word_t res;
  alunz_pkg::word_t sec;
  alunz_pkg::word_t fv;
  alunz_pkg::word_t diff;
  alunz_pkg::word_t shl_v;
  alunz_pkg::word_t shr_v;
  alunz_pkg::word_t sar_v;
  alunz_pkg::cnt_t  amt;
  logic             big;
  logic             wr;
  logic             ws;
  logic             upd;
  logic             taken;
  logic             derr;
  logic             cond;
  logic             new_n;
  logic             new_z;

  assign diff = a_q - b_q;
  assign amt  = b_q[alunz_pkg::CNT_BITS-1:0];
  assign big  = (b_q >= alunz_pkg::word_t'(W));

  // negative amount keeps A, oversized amount flushes to zero or sign
  always_comb begin
    if (b_q[W-1]) begin
      shl_v = a_q;
      shr_v = a_q;
      sar_v = a_q;
    end else if (big) begin
      shl_v = '0;
      shr_v = '0;
      sar_v = {W{a_q[W-1]}};
    end else begin
      shl_v = a_q << amt;
      shr_v = a_q >> amt;
      sar_v = alunz_pkg::word_t'($signed(a_q) >>> amt);
    end
  end

  always_comb begin
    res   = '0;
    sec   = '0;
    fv    = '0;
    wr    = 1'b0;
    ws    = 1'b0;
    upd   = 1'b0;
    taken = 1'b0;
    derr  = 1'b0;
    cond  = 1'b0;
    unique case (alunz_pkg::op_t'(op_q))
      alunz_pkg::OP_MOV: begin
        res = b_q;
        wr  = 1'b1;
      end
      alunz_pkg::OP_ADD: begin
        res = a_q + b_q;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_SUB: begin
        res = diff;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_MUL: begin
        res = prod;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_DIV: begin
        if (b_q == '0) begin
          derr = 1'b1;
        end else begin
          res = (neg_a != neg_b) ? (~quo + 1'b1) : quo;
          sec = neg_a ? (~rem + 1'b1) : rem;
          wr  = 1'b1;
          ws  = 1'b1;
          upd = 1'b1;
        end
      end
      alunz_pkg::OP_CMP: begin
        fv  = diff;
        upd = 1'b1;
      end
      alunz_pkg::OP_AND: begin
        res = a_q & b_q;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_OR: begin
        res = a_q | b_q;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_XOR: begin
        res = a_q ^ b_q;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_SWAP: begin
        res = b_q;
        sec = a_q;
        wr  = 1'b1;
        ws  = 1'b1;
      end
      alunz_pkg::OP_SHL: begin
        res = shl_v;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_SHR: begin
        res = shr_v;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_SAR: begin
        res = sar_v;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_LDH: begin
        res = (a_q & alunz_pkg::LOW_MASK) | (b_q << alunz_pkg::HALF_BITS);
        wr  = 1'b1;
      end
      alunz_pkg::OP_LDL: begin
        res = (a_q & ~alunz_pkg::LOW_MASK) | (b_q & alunz_pkg::LOW_MASK);
        wr  = 1'b1;
      end
      alunz_pkg::OP_NOT: begin
        res = ~a_q;
        wr  = 1'b1;
        upd = 1'b1;
      end
      alunz_pkg::OP_JMP: cond = 1'b1;
      alunz_pkg::OP_JZ:  cond = flag_z;
      alunz_pkg::OP_JP:  cond = !flag_n && !flag_z;
      alunz_pkg::OP_JN:  cond = flag_n;
      alunz_pkg::OP_JNZ: cond = !flag_z;
      alunz_pkg::OP_JNP: cond = flag_n || flag_z;
      alunz_pkg::OP_JNN: cond = !flag_n;
      default: ;
    endcase
    // jumps leave res at zero unless taken
    if (cond) begin
      taken = 1'b1;
      res   = a_q;
    end
    if (upd && !(alunz_pkg::op_t'(op_q) == alunz_pkg::OP_CMP)) begin
      fv = res;
    end
  end

  assign new_n = upd ? fv[W-1]  : flag_n;
  assign new_z = upd ? (fv == '0) : flag_z;

  // update flags on completion
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_n <= 1'b0;
      flag_z <= 1'b0;
    end else if (cmd.finish) begin
      flag_n <= new_n;
      flag_z <= new_z;
    end
  end

  // load the response register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_q.result        <= res;
      rsp_q.second_value  <= sec;
      rsp_q.write_result  <= wr;
      rsp_q.write_second  <= ws;
      rsp_q.flag_negative <= new_n;
      rsp_q.flag_zero     <= new_z;
      rsp_q.branch_taken  <= taken;
      rsp_q.divide_error  <= derr;
    end
  end

  assign rsp = rsp_q;

endmodule

// ===== rtl/core/alunz_ctrl.sv =====
// ----------------------------------------------------------------------------
// alunz_ctrl
// Controller: sequences each request through multiply or divide steps and
// owns the request/response handshake.
// ----------------------------------------------------------------------------
module alunz_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  input  alunz_pkg::sts_t sts,
  output alunz_pkg::cmd_t cmd
);

  alunz_pkg::state_t state;
  alunz_pkg::state_t state_next;
  logic              out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      alunz_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (sts.kind)
            alunz_pkg::KIND_MUL: state_next = alunz_pkg::S_MUL;
            alunz_pkg::KIND_DIV: state_next = alunz_pkg::S_DIV;
            default:             state_next = alunz_pkg::S_FIN;
          endcase
        end
      end
      alunz_pkg::S_MUL: state_next = alunz_pkg::S_FIN;
      alunz_pkg::S_DIV: begin
        if (sts.div_last) begin
          state_next = alunz_pkg::S_FIN;
        end
      end
      alunz_pkg::S_FIN: begin
        if (out_free) begin
          state_next = alunz_pkg::S_IDLE;
        end
      end
      default: state_next = alunz_pkg::S_IDLE;
    endcase
  end

  // datapath commands and request stall
  always_comb begin
    req_stall    = (state != alunz_pkg::S_IDLE);
    cmd.load     = (state == alunz_pkg::S_IDLE) && req_valid;
    cmd.mul_cap  = (state == alunz_pkg::S_MUL);
    cmd.div_step = (state == alunz_pkg::S_DIV);
    cmd.finish   = (state == alunz_pkg::S_FIN) && out_free;
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alunz_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_div_enters: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && sts.kind == alunz_pkg::KIND_DIV) |=> state == alunz_pkg::S_DIV)
    else $error("divide request did not enter the divide loop");

  a_div_stays: assert property (@(posedge clk) disable iff (rst)
    (state == alunz_pkg::S_DIV && !sts.div_last) |=> state == alunz_pkg::S_DIV)
    else $error("divide loop left early");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rsp_valid && rsp_stall))
    else $error("pending response overwritten");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (rsp_valid && state == alunz_pkg::S_IDLE))
    else $error("completed request not presented");

endmodule
